[hw/rtl/swv_dac_waveform_step_macros.svh]
// assertion macros for the square-wave voltammetry waveform step block
`ifndef SWV_DAC_WAVEFORM_STEP_MACROS_SVH
`define SWV_DAC_WAVEFORM_STEP_MACROS_SVH

// condition and consequence in the same cycle
`define SWV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swv check failed");

// consequence in the cycle after the condition
`define SWV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swv check failed");

`endif

[hw/rtl/swv_pkg.sv]
// shared types and constants of the square-wave voltammetry waveform step block
package swv_pkg;

  localparam int unsigned RAMP_W  = 22;
  localparam int unsigned VZ_W    = 6;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned BIAS_W  = 12;
  localparam int unsigned DAC_W   = VZ_W + BIAS_W;

  localparam logic [BIAS_W-1:0] BIAS_MAX = 12'd4095;

  // configuration registers as seen by the step logic
  typedef struct packed {
    logic [VZ_W-1:0]          vzero_start;
    logic [VZ_W-1:0]          vzero_peak;
    logic signed [RAMP_W-1:0] ramp_start;
    logic signed [RAMP_W-1:0] pulse;
    logic signed [RAMP_W-1:0] stair;
    logic [POS_W-1:0]         step_count;
  } swv_cfg_t;

  // one sweep update handed from the step logic to the bias logic
  typedef struct packed {
    logic signed [RAMP_W-1:0] ramp;
    logic [VZ_W-1:0]          vzero;
    logic                     was_high;
    logic                     done;
  } swv_upd_t;

endpackage

[hw/rtl/swv_step.sv]
// sweep state: phase machine, level flag, step position and saturating ramp
module swv_step import swv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     restart_i,
  input  swv_cfg_t cfg_i,
  output swv_upd_t upd_o
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam int unsigned WIDE_W = RAMP_W + 2;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(22'sh1FFFFF);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -(WIDE_W'(22'sh1FFFFF)) - WIDE_W'(1);

  logic [1:0]               phase_q, phase_d, phase_c;
  logic                     level_q, level_c;
  logic [POS_W-1:0]         pos_q, pos_c;
  logic signed [RAMP_W-1:0] ramp_q, ramp_d, ramp_c;
  logic [VZ_W-1:0]          vz_q, vz_d, vz_c;
  logic signed [WIDE_W-1:0] ramp_w, pulse_w, stair_w, half_w, sum_w;

  // restart view of the state, then phase transitions
  always_comb begin
    phase_c = restart_i ? PH_START : phase_q;
    level_c = restart_i | level_q;
    pos_c   = restart_i ? '0 : pos_q;
    ramp_c  = restart_i ? cfg_i.ramp_start : ramp_q;
    vz_c    = restart_i ? '0 : vz_q;
    phase_d = phase_c;
    vz_d    = vz_c;
    unique case (phase_c)
      PH_START: begin
        vz_d    = cfg_i.vzero_start;
        phase_d = PH_FIRST;
      end
      PH_FIRST: begin
        if (pos_c >= (cfg_i.step_count >> 1)) begin
          vz_d    = cfg_i.vzero_peak;
          phase_d = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (pos_c >= cfg_i.step_count) phase_d = PH_STOP;
      end
      PH_STOP: begin
        phase_d = PH_STOP;
      end
    endcase
  end

  // ramp update with saturation to the 22-bit range
  always_comb begin
    ramp_w  = WIDE_W'(ramp_c);
    pulse_w = WIDE_W'(cfg_i.pulse);
    stair_w = WIDE_W'(cfg_i.stair);
    // half pulse rounds toward zero
    half_w  = (pulse_w + (pulse_w[WIDE_W-1] ? WIDE_W'(1) : WIDE_W'(0))) >>> 1;
    if (level_c) begin
      sum_w = ramp_w - (pulse_w - stair_w);
    end else if (pos_c == POS_W'(1)) begin
      sum_w = ramp_w + half_w;
    end else begin
      sum_w = ramp_w + pulse_w;
    end
    if (sum_w > WIDE_MAX) begin
      ramp_d = WIDE_MAX[RAMP_W-1:0];
    end else if (sum_w < WIDE_MIN) begin
      ramp_d = WIDE_MIN[RAMP_W-1:0];
    end else begin
      ramp_d = sum_w[RAMP_W-1:0];
    end
  end

  // state registers advance once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      level_q <= 1'b1;
      pos_q   <= '0;
      ramp_q  <= '0;
      vz_q    <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      level_q <= ~level_c;
      pos_q   <= pos_c + POS_W'(1);
      ramp_q  <= ramp_d;
      vz_q    <= vz_d;
    end
  end

  assign upd_o.ramp     = ramp_d;
  assign upd_o.vzero    = vz_d;
  assign upd_o.was_high = level_c;
  assign upd_o.done     = (phase_d == PH_STOP);

endmodule

[hw/rtl/swv_bias.sv]
// bias code composition: vzero*64 plus ramp, truncate, floor fix-up and clamp
module swv_bias import swv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  swv_upd_t         upd_i,
  output logic [DAC_W-1:0] dac_word_o
);

  localparam int unsigned BASE_W = BIAS_W + 1;
  localparam int unsigned SUM_W  =
    ((BASE_W + FRAC_BITS) > RAMP_W ? (BASE_W + FRAC_BITS) : RAMP_W) + 1;
  localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic [BIAS_W-1:0]       base;
  logic signed [SUM_W-1:0] base_s, base_fx, sum, quo, adj;
  logic [BIAS_W-1:0]       bias;

  always_comb begin
    base    = {upd_i.vzero, 6'd0};
    base_s  = signed'(SUM_W'(base));
    base_fx = signed'(SUM_W'(base) << FRAC_BITS);
    sum     = base_fx + SUM_W'(upd_i.ramp);
    // arithmetic shift floors, so bump negatives with a fraction to truncate
    quo = sum >>> FRAC_BITS;
    if (sum[SUM_W-1] && ((sum & FRAC_MASK) != '0)) quo = quo + SUM_W'(1);
    adj = (quo < base_s) ? quo - SUM_W'(1) : quo;
    // clamp into the 12-bit bias range
    if (adj[SUM_W-1]) begin
      bias = '0;
    end else if (adj > signed'(SUM_W'(BIAS_MAX))) begin
      bias = BIAS_MAX;
    end else begin
      bias = adj[BIAS_W-1:0];
    end
  end

  assign dac_word_o = {upd_i.vzero, bias};

endmodule

[hw/rtl/swv_dac_waveform_step.sv]
// top level of the square-wave voltammetry waveform step block
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  request  | in_valid_i / in_stall_o      | restart_i
//  result   | out_valid_o / out_stall_i    | dac_word_o, phase_high_o, sweep_done_o
//  config   | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// one request per cycle while in_stall_o is low; a taken request goes on through the step stage and output register
// stages: input register, step stage (sweep state update), output register (bias)
// each stage loads when empty or when the stage after it moves on
// reset clears sweep state and configuration; payload registers are not reset
`include "swv_dac_waveform_step_macros.svh"
module swv_dac_waveform_step import swv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DAC_W-1:0]  dac_word_o,
  output logic              phase_high_o,
  output logic              sweep_done_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [RAMP_W-1:0] cfg_data_i
);

  localparam logic [2:0] REG_VZ_START  = 3'd0;
  localparam logic [2:0] REG_VZ_PEAK   = 3'd1;
  localparam logic [2:0] REG_RAMP_INIT = 3'd2;
  localparam logic [2:0] REG_PULSE     = 3'd3;
  localparam logic [2:0] REG_STAIR     = 3'd4;
  localparam logic [2:0] REG_STEPS     = 3'd5;

  swv_cfg_t         cfg_q;
  logic             s1_vq, s2_vq, out_vq;
  logic             restart_q;
  swv_upd_t         upd, s2_upd_q;
  logic [DAC_W-1:0] dac_word, dac_word_q;
  logic             phase_high_q, sweep_done_q;
  logic             out_ld, s2_ld, s1_ld, step_fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VZ_START:  cfg_q.vzero_start <= cfg_data_i[VZ_W-1:0];
        REG_VZ_PEAK:   cfg_q.vzero_peak  <= cfg_data_i[VZ_W-1:0];
        REG_RAMP_INIT: cfg_q.ramp_start  <= cfg_data_i;
        REG_PULSE:     cfg_q.pulse       <= cfg_data_i;
        REG_STAIR:     cfg_q.stair       <= cfg_data_i;
        REG_STEPS:     cfg_q.step_count  <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage load enables, back to front
  assign out_ld     = !out_vq || !out_stall_i;
  assign s2_ld      = !s2_vq || out_ld;
  assign s1_ld      = !s1_vq || s2_ld;
  assign step_fire  = s1_vq && s2_ld;
  assign in_stall_o = !s1_ld;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq <= 1'b0;
    end else if (s1_ld) begin
      s1_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld && in_valid_i) restart_q <= restart_i;
  end

  // sweep state update
  swv_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (step_fire),
    .restart_i (restart_q),
    .cfg_i     (cfg_q),
    .upd_o     (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vq <= 1'b0;
    end else if (s2_ld) begin
      s2_vq <= s1_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) s2_upd_q <= upd;
  end

  // bias composition
  swv_bias #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bias (
    .upd_i      (s2_upd_q),
    .dac_word_o (dac_word)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_ld) begin
      out_vq <= s2_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && s2_vq) begin
      dac_word_q   <= dac_word;
      phase_high_q <= s2_upd_q.was_high;
      sweep_done_q <= s2_upd_q.done;
    end
  end

  assign out_valid_o  = out_vq;
  assign dac_word_o   = dac_word_q;
  assign phase_high_o = phase_high_q;
  assign sweep_done_o = sweep_done_q;

  // checks on pipeline occupancy and restart handling
  `SWV_ASSERT_NEXT(a_s1_holds, s1_vq && !s2_ld, s1_vq)
  `SWV_ASSERT_NEXT(a_out_drains, out_vq && !out_stall_i && !s2_vq, !out_vq)
  `SWV_ASSERT_NEXT(a_restart_high, step_fire && restart_q, s2_vq && s2_upd_q.was_high)

endmodule
